// ===== sv/msme_pkg.sv =====
// Shared constants, types and address helper for the multi-stack move engine.
// No dependencies.
package msme_pkg;

  localparam int NUM_STACKS  = 9;
  localparam int STACK_DEPTH = 256;

  localparam int FLD_W  = 4;
  localparam int CNT_W  = 9;
  localparam int DATA_W = 8;
  localparam int STK_W  = $clog2(NUM_STACKS);
  localparam int ADDR_W = $clog2(NUM_STACKS * STACK_DEPTH);

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_MOVE = 1'b1;

  typedef struct packed {
    logic             we;
    logic [STK_W-1:0] waddr;
    logic [CNT_W-1:0] wdata;
    logic             re;
    logic [STK_W-1:0] raddr;
  } cnt_req_t;

  function automatic logic [ADDR_W-1:0] item_addr(input logic [FLD_W-1:0] stk,
                                                  input logic [CNT_W-1:0] idx);
    item_addr = ADDR_W'(stk) * ADDR_W'(STACK_DEPTH) + ADDR_W'(idx);
  endfunction

endpackage

// ===== sv/msme_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module msme_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/msme_counts.sv =====
// Per-stack fill counts: small memory with a valid bit per entry, registered read.
// Depends on msme_pkg.
module msme_counts (
  input  logic                    clk,
  input  logic                    rst,
  input  msme_pkg::cnt_req_t      req,
  output logic [msme_pkg::CNT_W-1:0] rdata
);
  import msme_pkg::*;

  logic [CNT_W-1:0]      mem [NUM_STACKS];
  logic [NUM_STACKS-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.we && (int'(req.waddr) < NUM_STACKS)) begin
      vld[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we && (int'(req.waddr) < NUM_STACKS)) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      if ((int'(req.raddr) < NUM_STACKS) && vld[req.raddr]) begin
        rdata <= mem[req.raddr];
      end else begin
        rdata <= '0;
      end
    end
  end

endmodule

// ===== sv/multi_stack_move_engine.sv =====
// Top level: request sequencer, item store and count store of the stack engine.
// Depends on msme_pkg, msme_ram and msme_counts.
//
// Nine LIFO stacks of bytes share one item RAM; fill counts live in a small
// count store. One item is worked at a time. The move loop passes one byte per
// cycle through the item RAM's read and write ports, then writes the last byte
// and leaves the loop. Refused requests and moves of zero skip the move loop.
// The next item is taken in the cycle after the result is loaded.
// No clearing pass is needed after reset. A new item is taken once the previous
// one has left the sequencer, even while its result still waits on the output.
module multi_stack_move_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          req_type,
  input  logic [7:0]                    item_value,
  input  logic [8:0]                    amount,
  input  logic [3:0]                    src_stack,
  input  logic [3:0]                    dst_stack,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    src_top,
  output logic [7:0]                    dst_top,
  output logic [8:0]                    src_count,
  output logic [8:0]                    dst_count,
  output logic                          error
);
  import msme_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDS  = 4'd1;
  localparam logic [3:0] S_RDD  = 4'd2;
  localparam logic [3:0] S_MOVE = 4'd3;
  localparam logic [3:0] S_WCS  = 4'd4;
  localparam logic [3:0] S_WCD  = 4'd5;
  localparam logic [3:0] S_TS   = 4'd6;
  localparam logic [3:0] S_TD   = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]        state, state_next;
  logic              req, req_next;
  logic [DATA_W-1:0] val, val_next;
  logic [CNT_W-1:0]  amt, amt_next;
  logic [FLD_W-1:0]  src, src_next;
  logic [FLD_W-1:0]  dst, dst_next;
  logic [CNT_W-1:0]  scnt, scnt_next;
  logic [CNT_W-1:0]  dcnt, dcnt_next;
  logic [CNT_W-1:0]  remaining, remaining_next;
  logic              pend, pend_next;
  logic              err, err_next;
  logic [DATA_W-1:0] stop, stop_next;

  cnt_req_t          creq;
  logic [CNT_W-1:0]  cnt_q;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_q;

  logic              in_acc, out_load;
  logic              src_ok, dst_ok;
  logic [CNT_W-1:0]  dcnt_rd;
  logic [CNT_W:0]    dsum;

  msme_ram #(
    .DEPTH (NUM_STACKS * STACK_DEPTH),
    .WIDTH (DATA_W)
  ) u_items (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  msme_counts u_counts (
    .clk   (clk),
    .rst   (rst),
    .req   (creq),
    .rdata (cnt_q)
  );

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign src_ok   = (int'(src) < NUM_STACKS);
  assign dst_ok   = (int'(dst) < NUM_STACKS);
  assign dcnt_rd  = dst_ok ? cnt_q : '0;
  assign dsum     = {1'b0, dcnt_rd} + {1'b0, amt};
  assign out_load = (state == S_FIN) && (!out_valid || !out_stall);

  always_comb begin
    state_next     = state;
    req_next       = req;
    val_next       = val;
    amt_next       = amt;
    src_next       = src;
    dst_next       = dst;
    scnt_next      = scnt;
    dcnt_next      = dcnt;
    remaining_next = remaining;
    pend_next      = pend;
    err_next       = err;
    stop_next      = stop;

    creq           = '0;
    ram_we         = 1'b0;
    ram_waddr      = item_addr(dst, dcnt);
    ram_wdata      = ram_q;
    ram_re         = 1'b0;
    ram_raddr      = item_addr(src, scnt - CNT_W'(1));

    case (state)
      S_IDLE: begin
        if (in_acc) begin
          req_next   = req_type;
          val_next   = item_value;
          amt_next   = amount;
          src_next   = src_stack;
          dst_next   = dst_stack;
          creq.re    = 1'b1;
          creq.raddr = STK_W'(src_stack);
          state_next = S_RDS;
        end
      end
      S_RDS: begin
        scnt_next  = src_ok ? cnt_q : '0;
        creq.re    = 1'b1;
        creq.raddr = STK_W'(dst);
        state_next = S_RDD;
      end
      S_RDD: begin
        dcnt_next      = dcnt_rd;
        remaining_next = amt;
        pend_next      = 1'b0;
        state_next     = S_WCS;
        if (req == REQ_PUSH) begin
          if (!dst_ok || (int'(dcnt_rd) >= STACK_DEPTH)) begin
            err_next = 1'b1;
          end else begin
            err_next  = 1'b0;
            ram_we    = 1'b1;
            ram_waddr = item_addr(dst, dcnt_rd);
            ram_wdata = val;
            dcnt_next = dcnt_rd + CNT_W'(1);
            if (src == dst) begin
              scnt_next = dcnt_rd + CNT_W'(1);
            end
          end
        end else begin
          if (!src_ok || !dst_ok || (amt > scnt)) begin
            err_next = 1'b1;
          end else if ((src != dst) && (int'(dsum) > STACK_DEPTH)) begin
            err_next = 1'b1;
          end else begin
            err_next = 1'b0;
            if ((src != dst) && (amt != '0)) begin
              state_next = S_MOVE;
            end
          end
        end
      end
      S_MOVE: begin
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = item_addr(dst, dcnt);
          ram_wdata = ram_q;
          dcnt_next = dcnt + CNT_W'(1);
        end
        if (remaining != '0) begin
          ram_re         = 1'b1;
          ram_raddr      = item_addr(src, scnt - CNT_W'(1));
          scnt_next      = scnt - CNT_W'(1);
          remaining_next = remaining - CNT_W'(1);
          pend_next      = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            state_next = S_WCS;
          end
        end
      end
      S_WCS: begin
        creq.we    = !err && (req == REQ_MOVE);
        creq.waddr = STK_W'(src);
        creq.wdata = scnt;
        state_next = S_WCD;
      end
      S_WCD: begin
        creq.we    = !err;
        creq.waddr = STK_W'(dst);
        creq.wdata = dcnt;
        state_next = S_TS;
      end
      S_TS: begin
        ram_re     = (scnt != '0);
        ram_raddr  = item_addr(src, scnt - CNT_W'(1));
        state_next = S_TD;
      end
      S_TD: begin
        stop_next  = (scnt != '0) ? ram_q : '0;
        ram_re     = (dcnt != '0);
        ram_raddr  = item_addr(dst, dcnt - CNT_W'(1));
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req       <= req_next;
    val       <= val_next;
    amt       <= amt_next;
    src       <= src_next;
    dst       <= dst_next;
    scnt      <= scnt_next;
    dcnt      <= dcnt_next;
    remaining <= remaining_next;
    err       <= err_next;
    stop      <= stop_next;
    if (out_load) begin
      src_top   <= stop;
      dst_top   <= (dcnt != '0) ? ram_q : '0;
      src_count <= scnt;
      dst_count <= dcnt;
      error     <= err;
    end
  end

endmodule

// ===== sim/tb_multi_stack_move_engine.sv =====
`timescale 1ns / 100ps
// Testbench for multi_stack_move_engine: a directed table, then random push and move traffic.
// Each result is checked against its table row or a stack-bank predictor. Depends on msme_pkg and the RTL.
module tb_multi_stack_move_engine;
  import msme_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_ITEMS = 1000;
  localparam int LONG_HOLD    = 600;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic [8:0] amount;
    logic [3:0] src;
    logic [3:0] dst;
  } stack_req_t;

  typedef struct packed {
    logic [7:0] src_top;
    logic [7:0] dst_top;
    logic [8:0] src_count;
    logic [8:0] dst_count;
    logic       refused;
  } stack_status_t;

  typedef struct {
    stack_req_t    req;
    bit            typed;
    stack_status_t res;
  } plan_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       req_type = 1'b0;
  logic [7:0] item_value = 8'h00;
  logic [8:0] amount = 9'd0;
  logic [3:0] src_stack = 4'd0;
  logic [3:0] dst_stack = 4'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] src_top;
  logic [7:0] dst_top;
  logic [8:0] src_count;
  logic [8:0] dst_count;
  logic       error;

  multi_stack_move_engine dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .item_value (item_value),
    .amount     (amount),
    .src_stack  (src_stack),
    .dst_stack  (dst_stack),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .src_top    (src_top),
    .dst_top    (dst_top),
    .src_count  (src_count),
    .dst_count  (dst_count),
    .error      (error)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  int unsigned   stack_fill [NUM_STACKS];
  logic [7:0]    stack_mem [NUM_STACKS][STACK_DEPTH];
  stack_status_t expected_q [$];
  plan_row_t     plan [$];
  int            items_sent = 0;
  int            burst_left = 0;
  int            fail_count = 0;
  int            idle_cycles = 0;
  bit            long_hold_done = 1'b0;

  initial begin
    foreach (stack_fill[i]) stack_fill[i] = 0;
  end

  function automatic logic [7:0] stack_top(logic [3:0] s);
    if (s >= NUM_STACKS) return 8'h00;
    if (stack_fill[s] == 0) return 8'h00;
    return stack_mem[s][stack_fill[s] - 1];
  endfunction

  function automatic logic [8:0] stack_count(logic [3:0] s);
    if (s >= NUM_STACKS) return 9'd0;
    return 9'(stack_fill[s]);
  endfunction

  function automatic stack_status_t apply_request(stack_req_t r);
    stack_status_t res;
    logic [7:0]    b;
    bit            refused;
    refused = 1'b0;
    if (r.kind == REQ_PUSH) begin
      if (r.dst >= NUM_STACKS || stack_fill[r.dst] >= STACK_DEPTH) begin
        refused = 1'b1;
      end else begin
        stack_mem[r.dst][stack_fill[r.dst]] = r.value;
        stack_fill[r.dst]++;
      end
    end else if (r.src >= NUM_STACKS || r.dst >= NUM_STACKS) begin
      refused = 1'b1;
    end else if (r.amount > stack_fill[r.src]) begin
      refused = 1'b1;
    end else if (r.src != r.dst) begin
      if (stack_fill[r.dst] + r.amount > STACK_DEPTH) begin
        refused = 1'b1;
      end else begin
        for (int i = 0; i < r.amount; i++) begin
          stack_fill[r.src]--;
          b = stack_mem[r.src][stack_fill[r.src]];
          stack_mem[r.dst][stack_fill[r.dst]] = b;
          stack_fill[r.dst]++;
        end
      end
    end
    res.src_top   = stack_top(r.src);
    res.dst_top   = stack_top(r.dst);
    res.src_count = stack_count(r.src);
    res.dst_count = stack_count(r.dst);
    res.refused   = refused;
    return res;
  endfunction

  function automatic stack_req_t mk_req(logic kind, logic [7:0] value, logic [8:0] amt,
                                        logic [3:0] src, logic [3:0] dst);
    stack_req_t r;
    r.kind   = kind;
    r.value  = value;
    r.amount = amt;
    r.src    = src;
    r.dst    = dst;
    return r;
  endfunction

  function automatic stack_req_t make_random_req();
    stack_req_t r;
    int         sel;
    int         lim;
    r = mk_req(REQ_MOVE, 8'($urandom), 9'($urandom_range(0, 511)),
               4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      r.kind = REQ_PUSH;
      if ($urandom_range(0, 9) != 0) r.dst = 4'($urandom_range(0, NUM_STACKS - 1));
    end else if (sel < 88) begin
      r.src = 4'($urandom_range(0, NUM_STACKS - 1));
      r.dst = 4'($urandom_range(0, NUM_STACKS - 1));
      lim = stack_fill[r.src];
      if ($urandom_range(0, 1) == 0 && lim > 4) lim = 4;
      r.amount = 9'($urandom_range(0, lim));
      if (r.src != r.dst && stack_fill[r.dst] + r.amount > STACK_DEPTH
          && $urandom_range(0, 3) != 0)
        r.amount = 9'(STACK_DEPTH - stack_fill[r.dst]);
    end else begin
      r.kind = 1'($urandom_range(0, 1));
    end
    return r;
  endfunction

  task automatic add_row(logic kind, logic [7:0] value, logic [8:0] amt, logic [3:0] src,
                         logic [3:0] dst, bit typed, logic [7:0] st, logic [7:0] dt,
                         logic [8:0] sc, logic [8:0] dc, logic e);
    plan_row_t row;
    row.req   = mk_req(kind, value, amt, src, dst);
    row.typed = typed;
    row.res   = {st, dt, sc, dc, e};
    plan.push_back(row);
  endtask

  task automatic send_req(stack_req_t r, bit typed, stack_status_t typed_res);
    stack_status_t predicted;
    int            gap;
    req_type   <= r.kind;
    item_value <= r.value;
    amount     <= r.amount;
    src_stack  <= r.src;
    dst_stack  <= r.dst;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = apply_request(r);
    expected_q.push_back(typed ? typed_res : predicted);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 15);
    end
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  // empty a second stack where room allows, fill one stack to the top, then exercise full, self-move and overflow cases
  task automatic fill_and_spill();
    logic [3:0] f;
    logic [3:0] g;
    logic [3:0] h;
    bit         found;
    f = 4'($urandom_range(0, NUM_STACKS - 1));
    g = 4'((f + $urandom_range(1, NUM_STACKS - 1)) % NUM_STACKS);
    found = 1'b0;
    h = 4'd0;
    for (int k = 0; k < NUM_STACKS; k++)
      if (k != f && k != g && stack_fill[k] + stack_fill[g] <= STACK_DEPTH) begin
        h = 4'(k);
        found = 1'b1;
      end
    if (found && stack_fill[g] > 0)
      send_req(mk_req(REQ_MOVE, 8'($urandom), 9'(stack_fill[g]), g, h), 1'b0, '0);
    while (stack_fill[f] < STACK_DEPTH)
      send_req(mk_req(REQ_PUSH, 8'($urandom), 9'($urandom_range(0, 511)),
                      4'($urandom_range(0, 15)), f), 1'b0, '0);
    repeat (2) send_req(mk_req(REQ_PUSH, 8'($urandom), 9'd0, g, f), 1'b0, '0);
    send_req(mk_req(REQ_MOVE, 8'h00, 9'd256, f, f), 1'b0, '0);
    send_req(mk_req(REQ_MOVE, 8'h00, 9'd257, f, g), 1'b0, '0);
    send_req(mk_req(REQ_MOVE, 8'h00, 9'd256, f, g), 1'b0, '0);
    send_req(mk_req(REQ_PUSH, 8'($urandom), 9'd0, g, f), 1'b0, '0);
    send_req(mk_req(REQ_MOVE, 8'h00, 9'd1, f, g), 1'b0, '0);
  endtask

  initial begin
    int  fills_done;
    bit  paused_mid;
    fills_done = 0;
    paused_mid = 1'b0;
    add_row(REQ_MOVE, 8'h00, 9'd0,   4'd0,  4'd8,  1, 8'h00, 8'h00, 9'd0, 9'd0, 1'b0);
    add_row(REQ_MOVE, 8'h00, 9'd1,   4'd0,  4'd1,  1, 8'h00, 8'h00, 9'd0, 9'd0, 1'b1);
    add_row(REQ_PUSH, 8'hFF, 9'd0,   4'd15, 4'd8,  1, 8'h00, 8'hFF, 9'd0, 9'd1, 1'b0);
    add_row(REQ_PUSH, 8'h00, 9'd0,   4'd0,  4'd9,  1, 8'h00, 8'h00, 9'd0, 9'd0, 1'b1);
    add_row(REQ_PUSH, 8'hA5, 9'd0,   4'd8,  4'd15, 1, 8'hFF, 8'h00, 9'd1, 9'd0, 1'b1);
    add_row(REQ_MOVE, 8'h00, 9'd0,   4'd9,  4'd0,  1, 8'h00, 8'h00, 9'd0, 9'd0, 1'b1);
    add_row(REQ_MOVE, 8'h00, 9'd0,   4'd8,  4'd15, 1, 8'hFF, 8'h00, 9'd1, 9'd0, 1'b1);
    add_row(REQ_PUSH, 8'h5A, 9'd0,   4'd8,  4'd8,  1, 8'h5A, 8'h5A, 9'd2, 9'd2, 1'b0);
    add_row(REQ_MOVE, 8'h00, 9'd2,   4'd8,  4'd0,  1, 8'h00, 8'hFF, 9'd0, 9'd2, 1'b0);
    add_row(REQ_MOVE, 8'h00, 9'd2,   4'd0,  4'd0,  0, 8'h00, 8'h00, 9'd0, 9'd0, 1'b0);
    add_row(REQ_MOVE, 8'h00, 9'd3,   4'd0,  4'd0,  1, 8'hFF, 8'hFF, 9'd2, 9'd2, 1'b1);
    add_row(REQ_MOVE, 8'hFF, 9'd511, 4'd0,  4'd1,  1, 8'hFF, 8'h00, 9'd2, 9'd0, 1'b1);
    add_row(REQ_PUSH, 8'h01, 9'd511, 4'd0,  4'd1,  0, 8'h00, 8'h00, 9'd0, 9'd0, 1'b0);
    add_row(REQ_PUSH, 8'h80, 9'd0,   4'd1,  4'd1,  0, 8'h00, 8'h00, 9'd0, 9'd0, 1'b0);
    add_row(REQ_MOVE, 8'h00, 9'd1,   4'd1,  4'd0,  0, 8'h00, 8'h00, 9'd0, 9'd0, 1'b0);
    add_row(REQ_MOVE, 8'h00, 9'd256, 4'd1,  4'd2,  0, 8'h00, 8'h00, 9'd0, 9'd0, 1'b0);
    add_row(REQ_PUSH, 8'h7F, 9'd0,   4'd15, 4'd0,  0, 8'h00, 8'h00, 9'd0, 9'd0, 1'b0);
    add_row(REQ_MOVE, 8'h00, 9'd0,   4'd15, 4'd15, 1, 8'h00, 8'h00, 9'd0, 9'd0, 1'b1);
    add_row(REQ_MOVE, 8'h00, 9'd4,   4'd0,  4'd7,  0, 8'h00, 8'h00, 9'd0, 9'd0, 1'b0);
    add_row(REQ_MOVE, 8'h00, 9'd0,   4'd7,  4'd0,  0, 8'h00, 8'h00, 9'd0, 9'd0, 1'b0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (plan[i]) send_req(plan[i].req, plan[i].typed, plan[i].res);
    pause_until_drained();
    while (items_sent < plan.size() + RANDOM_ITEMS) begin
      if ((fills_done == 0 && items_sent >= 300) || (fills_done == 1 && items_sent >= 750)) begin
        fill_and_spill();
        fills_done++;
      end else begin
        send_req(make_random_req(), 1'b0, '0);
      end
      if (!paused_mid && items_sent >= 500) begin
        pause_until_drained();
        paused_mid = 1'b1;
      end
    end
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    int n;
    int mode;
    repeat (4) @(posedge clk);
    forever begin
      if (!long_hold_done && items_sent >= 150) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 9);
        n = $urandom_range(1, 40);
        if (mode < 3) begin
          out_stall <= 1'b0;
          repeat (n) @(posedge clk);
        end else if (mode < 5) begin
          out_stall <= 1'b1;
          repeat ((n % 8) + 1) @(posedge clk);
        end else begin
          repeat (n) begin
            out_stall <= ($urandom_range(0, 2) == 0);
            @(posedge clk);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    stack_status_t got;
    stack_status_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      got = {src_top, dst_top, src_count, dst_count, error};
      if (expected_q.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result item: top %h/%h count %0d/%0d error %b",
                   got.src_top, got.dst_top, got.src_count, got.dst_count, got.refused);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (got.src_top !== want.src_top || got.dst_top !== want.dst_top ||
            got.src_count !== want.src_count || got.dst_count !== want.dst_count ||
            got.refused !== want.refused) begin
          if (fail_count < 10)
            $display("mismatch: expected top %h/%h count %0d/%0d error %b, got top %h/%h count %0d/%0d error %b",
                     want.src_top, want.dst_top, want.src_count, want.dst_count, want.refused,
                     got.src_top, got.dst_top, got.src_count, got.dst_count, got.refused);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
sv/msme_pkg.sv
sv/msme_ram.sv
sv/msme_counts.sv
sv/multi_stack_move_engine.sv
sim/tb_multi_stack_move_engine.sv
